>>> src/mme_pkg.sv
package mme_pkg;

    localparam int MAX_DIM     = 8;
    localparam int DIM_W       = 4;
    localparam int POS_W       = 3;
    localparam int STORE_DEPTH = 64;
    localparam int ADDR_W      = 6;
    localparam int ELEM_W      = 16;
    localparam int PROD_W      = 32;
    localparam int SUM_W       = 40;
    localparam int CFG_IDX_W   = 2;

    // command codes
    localparam logic [1:0] CMD_LOAD_A = 2'd0;
    localparam logic [1:0] CMD_LOAD_B = 2'd1;
    localparam logic [1:0] CMD_START  = 2'd2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_A_ROWS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_A_COLS = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_B_COLS = 2'd2;

    localparam logic [DIM_W-1:0] DIM_RESET = DIM_W'(MAX_DIM);

    typedef struct packed {
        logic [1:0]               command;
        logic [ADDR_W-1:0]        index;
        logic signed [ELEM_W-1:0] value;
    } t_in_item;

    typedef struct packed {
        logic [POS_W-1:0]        row;
        logic [POS_W-1:0]        column;
        logic signed [SUM_W-1:0] product_sum;
        logic                    last;
    } t_out_item;

    // per-term tag travelling down the datapath
    typedef struct packed {
        logic             first;
        logic             last_term;
        logic             zero;
        logic             final_item;
        logic [POS_W-1:0] row;
        logic [POS_W-1:0] column;
    } t_tag;

    typedef struct packed {
        logic              wr_a;
        logic              wr_b;
        logic              issue;
        t_tag              tag;
        logic [ADDR_W-1:0] a_addr;
        logic [ADDR_W-1:0] b_addr;
    } t_dp_ctrl;

    typedef struct packed {
        logic pipe_busy;
    } t_dp_status;

    function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] d);
        logic [DIM_W-1:0] r;
        r = (d > DIM_W'(MAX_DIM)) ? DIM_W'(MAX_DIM) : d;
        return r;
    endfunction

endpackage

>>> src/matrix_multiply_engine_unit.sv
// channel   direction  handshake                      payload
// item      in         start & !busy                  i_item (command, index, value)
// result    out        o_result_strobe, one cycle     o_result (row, column, sum, last)
// config    in         i_cfg_valid & o_cfg_ready      i_cfg_index, i_cfg_data
//
// a load transaction is taken on accept; busy stays low
// a start with n = rows * cols * max(1, inner) drains its n terms before the next accept,
//   issuing one multiply-accumulate per cycle through the shared multiplier
// results leave through the result register after the operand and product stages, row by row
// synchronous active-low reset; store contents are not cleared
// the receiver cannot stall, so results never back up
module matrix_multiply_engine_unit
    import mme_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // item channel
    input  logic                 start,
    output logic                 busy,
    input  t_in_item             i_item,
    // result channel
    output t_out_item            o_result,
    output logic                 o_result_strobe,
    // configuration channel
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [DIM_W-1:0]     i_cfg_data
);

    // command and status between sequencer and datapath
    t_dp_ctrl   dp_ctrl;
    t_dp_status dp_status;

    // sequencer: dimension registers, loop counters and address generation
    mme_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_command   (i_item.command),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_status    (dp_status),
        .o_ctrl      (dp_ctrl)
    );

    // datapath: both element stores, multiplier, accumulator, result register
    mme_dp u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_item          (i_item),
        .i_ctrl          (dp_ctrl),
        .o_status        (dp_status),
        .o_result        (o_result),
        .o_result_strobe (o_result_strobe)
    );

endmodule

>>> src/mme_ram.sv
module mme_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> src/mme_dp.sv
module mme_dp
    import mme_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_in_item   i_item,
    input  t_dp_ctrl   i_ctrl,
    output t_dp_status o_status,
    output t_out_item  o_result,
    output logic       o_result_strobe
);

    logic [ELEM_W-1:0] a_rdata;
    logic [ELEM_W-1:0] b_rdata;

    // stage 1: operands out of the stores
    logic r_s1_valid;
    t_tag r_s1_tag;
    // stage 2: product
    logic                     r_s2_valid;
    t_tag                     r_s2_tag;
    logic signed [PROD_W-1:0] r_s2_prod;
    logic signed [PROD_W-1:0] n_s2_prod;
    // accumulator and result
    logic signed [SUM_W-1:0]  r_acc;
    logic signed [SUM_W-1:0]  n_acc;
    logic                     r_strobe;
    t_out_item                r_result;

    mme_ram #(.WIDTH(ELEM_W), .DEPTH(STORE_DEPTH)) u_store_a (
        .i_clk   (i_clk),
        .i_we    (i_ctrl.wr_a),
        .i_waddr (i_item.index),
        .i_wdata (i_item.value),
        .i_raddr (i_ctrl.a_addr),
        .o_rdata (a_rdata)
    );

    mme_ram #(.WIDTH(ELEM_W), .DEPTH(STORE_DEPTH)) u_store_b (
        .i_clk   (i_clk),
        .i_we    (i_ctrl.wr_b),
        .i_waddr (i_item.index),
        .i_wdata (i_item.value),
        .i_raddr (i_ctrl.b_addr),
        .o_rdata (b_rdata)
    );

    always_comb begin
        if (r_s1_tag.zero) begin
            n_s2_prod = '0;
        end else begin
            n_s2_prod = $signed(a_rdata) * $signed(b_rdata);
        end
    end

    always_comb begin
        if (r_s2_tag.first) begin
            n_acc = SUM_W'(r_s2_prod);
        end else begin
            n_acc = r_acc + SUM_W'(r_s2_prod);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
            r_strobe   <= 1'b0;
        end else begin
            r_s1_valid <= i_ctrl.issue;
            r_s2_valid <= r_s1_valid;
            r_strobe   <= r_s2_valid && r_s2_tag.last_term;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s1_tag  <= i_ctrl.tag;
        r_s2_tag  <= r_s1_tag;
        r_s2_prod <= n_s2_prod;
        if (r_s2_valid) begin
            r_acc <= n_acc;
        end
        if (r_s2_valid && r_s2_tag.last_term) begin
            r_result.row         <= r_s2_tag.row;
            r_result.column      <= r_s2_tag.column;
            r_result.product_sum <= n_acc;
            r_result.last        <= r_s2_tag.final_item;
        end
    end

    assign o_status.pipe_busy = r_s1_valid || r_s2_valid;
    assign o_result           = r_result;
    assign o_result_strobe    = r_strobe;

endmodule

>>> src/mme_ctrl.sv
module mme_ctrl
    import mme_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 start,
    output logic                 busy,
    input  logic [1:0]           i_command,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [DIM_W-1:0]     i_cfg_data,
    input  t_dp_status           i_status,
    output t_dp_ctrl             o_ctrl
);

    typedef enum logic [2:0] {
        S_IDLE  = 3'b001,
        S_RUN   = 3'b010,
        S_DRAIN = 3'b100
    } t_state;

    t_state r_state, n_state;

    logic [DIM_W-1:0] r_cfg_a_rows, r_cfg_a_cols, r_cfg_b_cols;

    logic [DIM_W-1:0]  r_rows, r_inner, r_cols;
    logic [DIM_W-1:0]  n_rows, n_inner, n_cols;
    logic              r_zero, n_zero;
    logic [POS_W-1:0]  r_i, r_k, r_j, n_i, n_k, n_j;
    logic [ADDR_W-1:0] r_a_base, r_b_addr, n_a_base, n_b_addr;

    logic             accept;
    logic             start_go;
    logic [DIM_W-1:0] rows_c, inner_c, cols_c;
    logic             last_term, last_col, last_row, final_item;

    assign accept      = start && (r_state == S_IDLE);
    assign busy        = (r_state != S_IDLE);
    assign o_cfg_ready = 1'b1;

    assign rows_c   = clamp_dim(r_cfg_a_rows);
    assign inner_c  = clamp_dim(r_cfg_a_cols);
    assign cols_c   = clamp_dim(r_cfg_b_cols);
    assign start_go = accept && (i_command == CMD_START)
                      && (rows_c != '0) && (cols_c != '0);

    assign last_term  = r_zero || ({1'b0, r_j} == r_inner - 1'b1);
    assign last_col   = ({1'b0, r_k} == r_cols - 1'b1);
    assign last_row   = ({1'b0, r_i} == r_rows - 1'b1);
    assign final_item = last_term && last_col && last_row;

    always_comb begin
        o_ctrl.wr_a           = accept && (i_command == CMD_LOAD_A);
        o_ctrl.wr_b           = accept && (i_command == CMD_LOAD_B);
        o_ctrl.issue          = (r_state == S_RUN);
        o_ctrl.tag.first      = (r_j == '0);
        o_ctrl.tag.last_term  = last_term;
        o_ctrl.tag.zero       = r_zero;
        o_ctrl.tag.final_item = final_item;
        o_ctrl.tag.row        = r_i;
        o_ctrl.tag.column     = r_k;
        o_ctrl.a_addr         = r_a_base + ADDR_W'(r_j);
        o_ctrl.b_addr         = r_b_addr;
    end

    always_comb begin
        n_state  = r_state;
        n_rows   = r_rows;
        n_inner  = r_inner;
        n_cols   = r_cols;
        n_zero   = r_zero;
        n_i      = r_i;
        n_k      = r_k;
        n_j      = r_j;
        n_a_base = r_a_base;
        n_b_addr = r_b_addr;
        case (r_state)
            S_IDLE: begin
                if (start_go) begin
                    n_state  = S_RUN;
                    n_rows   = rows_c;
                    n_inner  = inner_c;
                    n_cols   = cols_c;
                    n_zero   = (inner_c == '0);
                    n_i      = '0;
                    n_k      = '0;
                    n_j      = '0;
                    n_a_base = '0;
                    n_b_addr = '0;
                end
            end
            S_RUN: begin
                if (last_term) begin
                    n_j = '0;
                    if (last_col) begin
                        n_k      = '0;
                        n_i      = r_i + 1'b1;
                        n_a_base = r_a_base + ADDR_W'(r_inner);
                        n_b_addr = '0;
                    end else begin
                        n_k      = r_k + 1'b1;
                        n_b_addr = ADDR_W'(r_k) + 1'b1;
                    end
                end else begin
                    n_j      = r_j + 1'b1;
                    n_b_addr = r_b_addr + ADDR_W'(r_cols);
                end
                if (final_item) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                if (!i_status.pipe_busy) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_cfg_a_rows <= DIM_RESET;
            r_cfg_a_cols <= DIM_RESET;
            r_cfg_b_cols <= DIM_RESET;
        end else begin
            r_state <= n_state;
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    CFG_A_ROWS: r_cfg_a_rows <= i_cfg_data;
                    CFG_A_COLS: r_cfg_a_cols <= i_cfg_data;
                    CFG_B_COLS: r_cfg_b_cols <= i_cfg_data;
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_rows   <= n_rows;
        r_inner  <= n_inner;
        r_cols   <= n_cols;
        r_zero   <= n_zero;
        r_i      <= n_i;
        r_k      <= n_k;
        r_j      <= n_j;
        r_a_base <= n_a_base;
        r_b_addr <= n_b_addr;
    end

`ifndef ASSERT_OFF
    // loads only land while no product is being worked on
    a_load_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_ctrl.wr_a || o_ctrl.wr_b) |-> (r_state == S_IDLE))
        else $error("store written while a multiply is in progress");

    a_pos_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RUN) |-> ({1'b0, r_i} < r_rows) && ({1'b0, r_k} < r_cols))
        else $error("result position beyond the latched dimensions");

    a_term_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RUN) && !r_zero |-> ({1'b0, r_j} < r_inner))
        else $error("inner index beyond the sum length");

    a_final_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RUN) && final_item |=> (r_state == S_DRAIN))
        else $error("last term issued without moving to drain");
`endif

endmodule

>>> sim/matrix_multiply_engine_unit_tb.sv
module matrix_multiply_engine_unit_tb
    import mme_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    // command code the block must ignore
    localparam logic [1:0] CMD_UNUSED = 2'd3;

    // stimulus stops once this many meaningful transactions have gone in
    localparam int ITEM_TARGET = 420;
    // settling time after the last awaited element, covers a start with no results
    localparam int IDLE_SETTLE = 8;
    // upper bound on cycles spent waiting for outstanding elements
    localparam int DRAIN_GUARD = 20000;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n;
    logic                 start;
    logic                 busy;
    t_in_item             i_item;
    t_out_item            o_result;
    logic                 o_result_strobe;
    logic                 i_cfg_valid;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index;
    logic [DIM_W-1:0]     i_cfg_data;

    // shadow copy of the block: both stores and the three dimension registers
    logic signed [ELEM_W-1:0] a_shadow [STORE_DEPTH];
    logic signed [ELEM_W-1:0] b_shadow [STORE_DEPTH];
    logic [DIM_W-1:0]         rows_cfg;
    logic [DIM_W-1:0]         inner_cfg;
    logic [DIM_W-1:0]         cols_cfg;

    // elements of C still to come out of the block, oldest first
    t_out_item c_due [$];
    t_out_item want_elem;
    t_out_item got_elem;

    // stimulus side bookkeeping: entries loaded since reset, current dimensions
    logic [STORE_DEPTH-1:0] a_loaded = '0;
    logic [STORE_DEPTH-1:0] b_loaded = '0;
    int                     set_rows;
    int                     set_inner;
    int                     set_cols;

    int error_count     = 0;
    int items_sent      = 0;
    int starts_sent     = 0;
    int results_checked = 0;
    int cfg_writes      = 0;
    int burst_left      = 1;

    matrix_multiply_engine_unit u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .start           (start),
        .busy            (busy),
        .i_item          (i_item),
        .o_result        (o_result),
        .o_result_strobe (o_result_strobe),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data)
    );

    // 2 ns clock
    always #1 i_clk = ~i_clk;

    // a dimension register above the maximum behaves as the maximum
    function automatic int eff_dim(input logic [DIM_W-1:0] d);
        return (d > MAX_DIM) ? MAX_DIM : int'(d);
    endfunction

    // random Q8.8 element, weighted towards the extremes and zero
    function automatic logic [ELEM_W-1:0] rand_elem();
        case ($urandom_range(0, 7))
            0: return 16'h7FFF;
            1: return 16'h8000;
            2: return 16'h0000;
            default: return ELEM_W'($urandom);
        endcase
    endfunction

    // mostly small matrices, now and then the full size, zero or above range
    function automatic logic [DIM_W-1:0] pick_dim();
        int r;
        r = $urandom_range(0, 99);
        if (r < 5)
            return '0;
        else if (r < 70)
            return DIM_W'($urandom_range(1, 3));
        else if (r < 88)
            return DIM_W'($urandom_range(4, 8));
        else
            return DIM_W'($urandom_range(9, 15));
    endfunction

    task automatic report_mismatch(input string msg);
        $display("%0t ns  mismatch: %s", $time, msg);
        error_count++;
    endtask

    // every element of C for the current shadow stores and dimensions
    task automatic predict_product();
        int        rows;
        int        inner;
        int        cols;
        longint    acc;
        t_out_item elem;
        rows  = eff_dim(rows_cfg);
        inner = eff_dim(inner_cfg);
        cols  = eff_dim(cols_cfg);
        for (int i = 0; i < rows; i++) begin
            for (int k = 0; k < cols; k++) begin
                acc = 0;
                for (int j = 0; j < inner; j++) begin
                    acc += longint'(a_shadow[(i * inner + j) % STORE_DEPTH])
                         * longint'(b_shadow[(j * cols + k) % STORE_DEPTH]);
                end
                elem.row         = POS_W'(i);
                elem.column      = POS_W'(k);
                elem.product_sum = acc[SUM_W-1:0];
                elem.last        = (i + 1 == rows) && (k + 1 == cols);
                c_due.push_back(elem);
            end
        end
    endtask

    // monitor: tracks config and item transactions, checks each result element
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            rows_cfg  = DIM_RESET;
            inner_cfg = DIM_RESET;
            cols_cfg  = DIM_RESET;
        end else begin
            // results first: a new start never overlaps the tail of the last one
            if (o_result_strobe) begin
                got_elem = o_result;
                if (c_due.size() == 0) begin
                    report_mismatch($sformatf("unexpected element row %0d col %0d sum %0d",
                        got_elem.row, got_elem.column, got_elem.product_sum));
                end else begin
                    want_elem = c_due.pop_front();
                    if (got_elem.row !== want_elem.row || got_elem.column !== want_elem.column
                        || got_elem.product_sum !== want_elem.product_sum
                        || got_elem.last !== want_elem.last) begin
                        report_mismatch($sformatf(
                            "got (%0d,%0d) sum %0d last %b, want (%0d,%0d) sum %0d last %b",
                            got_elem.row, got_elem.column, got_elem.product_sum,
                            got_elem.last, want_elem.row, want_elem.column,
                            want_elem.product_sum, want_elem.last));
                    end
                    results_checked++;
                end
            end
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    CFG_A_ROWS: rows_cfg  = i_cfg_data;
                    CFG_A_COLS: inner_cfg = i_cfg_data;
                    CFG_B_COLS: cols_cfg  = i_cfg_data;
                    default: ;
                endcase
            end
            if (start && !busy) begin
                case (i_item.command)
                    CMD_LOAD_A: a_shadow[i_item.index] = i_item.value;
                    CMD_LOAD_B: b_shadow[i_item.index] = i_item.value;
                    CMD_START:  predict_product();
                    default: ;
                endcase
            end
        end
    end

    // one item transaction; start stays high through a burst, random gap after it
    task automatic send_item(input logic [1:0] cmd, input int idx,
                             input logic [ELEM_W-1:0] val);
        t_in_item it;
        it.command = cmd;
        it.index   = ADDR_W'(idx);
        it.value   = val;
        start  <= 1'b1;
        i_item <= it;
        do @(posedge i_clk); while (busy);
        if (cmd == CMD_LOAD_A)
            a_loaded[idx] = 1'b1;
        else if (cmd == CMD_LOAD_B)
            b_loaded[idx] = 1'b1;
        if (cmd != CMD_UNUSED)
            items_sent++;
        if (cmd == CMD_START)
            starts_sent++;
        burst_left--;
        if (burst_left <= 0) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
            // occasional long bursts give stretches with no idling at all
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(16, 40)
                                                     : $urandom_range(1, 8);
        end
    endtask

    // drop start, let every awaited element arrive, then let the block settle
    task automatic wait_idle();
        int guard;
        guard = 0;
        start <= 1'b0;
        @(posedge i_clk);
        while (c_due.size() != 0 && guard < DRAIN_GUARD) begin
            @(posedge i_clk);
            guard++;
        end
        repeat (IDLE_SETTLE) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [DIM_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        cfg_writes++;
    endtask

    // all three dimensions, valid held high across the three transactions
    task automatic write_dims(input logic [DIM_W-1:0] r, input logic [DIM_W-1:0] c,
                              input logic [DIM_W-1:0] b);
        write_reg(CFG_A_ROWS, r);
        write_reg(CFG_A_COLS, c);
        write_reg(CFG_B_COLS, b);
        i_cfg_valid <= 1'b0;
        set_rows  = eff_dim(r);
        set_inner = eff_dim(c);
        set_cols  = eff_dim(b);
    endtask

    // 1x1 products at the corners of the Q8.8 range
    task automatic test_single_element_extremes();
        write_dims(4'd1, 4'd1, 4'd1);
        // largest positive squared
        send_item(CMD_LOAD_A, 0, 16'h7FFF);
        send_item(CMD_LOAD_B, 0, 16'h7FFF);
        send_item(CMD_START, 0, 16'h0000);
        // most negative squared, with index and value on the start at their top
        send_item(CMD_LOAD_A, 0, 16'h8000);
        send_item(CMD_LOAD_B, 0, 16'h8000);
        send_item(CMD_START, STORE_DEPTH - 1, 16'hFFFF);
        // most negative times largest positive; the unused command must not touch A
        send_item(CMD_LOAD_B, 0, 16'h7FFF);
        send_item(CMD_UNUSED, 0, 16'h1234);
        send_item(CMD_START, 0, 16'h0000);
        wait_idle();
    endtask

    // zero dimensions and a dimension register above the maximum
    task automatic test_dimension_corners();
        // no rows: nothing comes out
        write_dims(4'd0, 4'd1, 4'd1);
        send_item(CMD_START, 0, 16'h0000);
        wait_idle();
        // no columns: nothing comes out
        write_dims(4'd1, 4'd1, 4'd0);
        send_item(CMD_START, 0, 16'h0000);
        wait_idle();
        // empty inner sum: a single zero element
        write_dims(4'd1, 4'd0, 4'd1);
        send_item(CMD_START, 0, 16'h0000);
        wait_idle();
        // 15 rows behave as 8, giving a column of eight elements
        write_dims(4'd15, 4'd1, 4'd1);
        for (int i = 1; i < MAX_DIM; i++)
            send_item(CMD_LOAD_A, i, (i % 2) ? 16'h7FFF : 16'hFF01);
        send_item(CMD_LOAD_A, STORE_DEPTH - 1, 16'h8000);
        send_item(CMD_LOAD_B, STORE_DEPTH - 1, 16'h7FFF);
        send_item(CMD_START, 0, 16'h0000);
        wait_idle();
    endtask

    // random dimensions per phase; mostly full reloads, some partial updates and noise
    task automatic test_random_products();
        int mode;
        int addr;
        while (items_sent < ITEM_TARGET) begin
            write_dims(pick_dim(), pick_dim(), pick_dim());
            repeat ($urandom_range(1, 3)) begin
                mode = $urandom_range(0, 19);
                if (mode < 12) begin
                    // well-formed: reload both operands with random content
                    for (int i = 0; i < set_rows; i++)
                        for (int j = 0; j < set_inner; j++)
                            send_item(CMD_LOAD_A, i * set_inner + j, rand_elem());
                    for (int j = 0; j < set_inner; j++)
                        for (int k = 0; k < set_cols; k++)
                            send_item(CMD_LOAD_B, j * set_cols + k, rand_elem());
                end else if (mode < 17) begin
                    // broken sequence: only a few elements change before the start
                    repeat ($urandom_range(1, 4)) begin
                        if ($urandom_range(0, 1) && set_rows * set_inner > 0) begin
                            addr = $urandom_range(0, set_rows - 1) * set_inner
                                 + $urandom_range(0, set_inner - 1);
                            send_item(CMD_LOAD_A, addr, rand_elem());
                        end else if (set_inner * set_cols > 0) begin
                            addr = $urandom_range(0, set_inner - 1) * set_cols
                                 + $urandom_range(0, set_cols - 1);
                            send_item(CMD_LOAD_B, addr, rand_elem());
                        end
                    end
                end else begin
                    // noise: loads anywhere in the stores and ignored commands
                    repeat ($urandom_range(1, 6)) begin
                        case ($urandom_range(0, 2))
                            0: send_item(CMD_LOAD_A, $urandom_range(0, STORE_DEPTH - 1),
                                         rand_elem());
                            1: send_item(CMD_LOAD_B, $urandom_range(0, STORE_DEPTH - 1),
                                         rand_elem());
                            default: send_item(CMD_UNUSED, $urandom_range(0, STORE_DEPTH - 1),
                                               ELEM_W'($urandom));
                        endcase
                    end
                end
                // every entry the product reads has to hold a loaded value
                for (int i = 0; i < set_rows; i++)
                    for (int j = 0; j < set_inner; j++)
                        if (!a_loaded[i * set_inner + j])
                            send_item(CMD_LOAD_A, i * set_inner + j, rand_elem());
                for (int j = 0; j < set_inner; j++)
                    for (int k = 0; k < set_cols; k++)
                        if (!b_loaded[j * set_cols + k])
                            send_item(CMD_LOAD_B, j * set_cols + k, rand_elem());
                send_item(CMD_START, $urandom_range(0, STORE_DEPTH - 1), ELEM_W'($urandom));
            end
            wait_idle();
        end
    endtask

    initial begin
        start       <= 1'b0;
        i_item      <= '0;
        i_cfg_valid <= 1'b0;
        i_cfg_index <= '0;
        i_cfg_data  <= '0;
        i_rst_n     <= 1'b0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_single_element_extremes();
        test_dimension_corners();
        test_random_products();

        // final drain, then anything still awaited is a failure
        wait_idle();
        if (c_due.size() != 0)
            report_mismatch($sformatf("%0d elements never arrived", c_due.size()));

        $display("covered %0d transactions including %0d multiplies, %0d elements checked",
                 items_sent, starts_sent, results_checked);
        $display("dimension registers written %0d times, zero and above-range values included",
                 cfg_writes);
        if (error_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

    // watchdog, far beyond the slowest legal run
    initial begin
        #2000000;
        $display("DONE: errors detected");
        $finish;
    end

endmodule

>>> filelist.f
src/mme_pkg.sv
src/mme_ram.sv
src/mme_dp.sv
src/mme_ctrl.sv
src/matrix_multiply_engine_unit.sv
sim/matrix_multiply_engine_unit_tb.sv
